@@ hdl/pfa_pkg.sv @@
package pfa_pkg;

    // field widths on the stream ports
    localparam int OP_W     = 3;
    localparam int FIELD_W  = 64;

    // bit positions of the request fields inside s_tdata
    localparam int OP_LSB   = 0;
    localparam int A_LSB    = OP_LSB + OP_W;
    localparam int B_LSB    = A_LSB + FIELD_W;
    localparam int REQ_BITS = B_LSB + FIELD_W;
    localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;

    // modulus after reset
    localparam logic [FIELD_W-1:0] MODULUS_RESET = 64'hFFFF_FFFF_FFFF_FFC5;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_NEG = 3'd3;
    localparam logic [OP_W-1:0] OP_POW = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_EXEC,
        ST_MUL,
        ST_POW_SQ,
        ST_POW_MUL,
        ST_FINISH
    } state_t;

endpackage

@@ hdl/pfa_modmul.sv @@
module pfa_modmul #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    input  logic [WORD_BITS-1:0] p,
    output logic                 done,
    output logic [WORD_BITS-1:0] prod
);

    localparam int CW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] y_reg, y_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [WORD_BITS+1:0] s0, p1, p2;

    // one multiplier bit per cycle, msb first: r = (2r + bit*x) mod p
    always_comb
    begin
        p1 = {2'b00, p};
        p2 = {1'b0, p, 1'b0};
        s0 = {1'b0, r_reg, 1'b0} + {2'b00, (y_reg[WORD_BITS-1] ? x : '0)};
        y_next    = y_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            y_next    = y;
            r_next    = '0;
            cnt_next  = CW'(WORD_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // sum stays below 3p, so at most two subtractions
            if (s0 >= p2)
                r_next = WORD_BITS'(s0 - p2);
            else if (s0 >= p1)
                r_next = WORD_BITS'(s0 - p1);
            else
                r_next = s0[WORD_BITS-1:0];
            y_next   = {y_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign prod = r_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("modmul started while busy");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && p >= WORD_BITS'(2)) |=> (r_reg < p))
        else $error("modmul accumulator not reduced");

    a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("modmul finished without done");
`endif

endmodule

@@ hdl/prime_field_alu.sv @@
// Prime field ALU: one request (op, operand_a, operand_b) gives one result below the modulus
// held in the configuration register (cfg_data; cfg_ready is always high, so software must
// write it only while no request is in flight, which the block itself does not enforce).
// Ops are add, subtract, multiply, negate and power; a modulus below two gives zero for
// every op and codes five to seven give zero. Both operands are first reduced modulo p,
// and all products run through one bit-serial modular multiplier that handles one
// multiplier bit per cycle. Add, subtract and negate need only the two reductions, multiply
// adds one more product, and power runs square-and-multiply over every exponent bit. The
// next request is taken while a finished result still waits in the output register.
module prime_field_alu #(
    parameter int WORD_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pfa_pkg::REQ_W-1:0]   s_tdata,    // op[2:0], operand_a[66:3], operand_b[130:67]
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pfa_pkg::FIELD_W-1:0] m_tdata,    // result[63:0]
    // modulus write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pfa_pkg::FIELD_W-1:0] cfg_data
);

    localparam int CW = $clog2(WORD_BITS);

    pfa_pkg::state_t state_reg, state_next;

    logic [pfa_pkg::OP_W-1:0] op_reg, op_next;
    logic [WORD_BITS-1:0]     a_reg, a_next;      // reduced operand_a
    logic [WORD_BITS-1:0]     b_reg, b_next;      // reduced operand_b
    logic [WORD_BITS-1:0]     e_reg, e_next;      // raw operand_b, shifted left for power
    logic [WORD_BITS-1:0]     t_reg, t_next;      // power accumulator
    logic [CW-1:0]            pcnt_reg, pcnt_next;
    logic [WORD_BITS-1:0]     res_reg, res_next;
    logic [WORD_BITS-1:0]     p_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]     out_data_reg, out_data_next;

    logic                     p_small;
    logic [WORD_BITS-1:0]     add_res, sub_res, neg_res, diff;
    logic [WORD_BITS:0]       sum, sum_p;

    // shared multiplier
    logic                     mm_start;
    logic [WORD_BITS-1:0]     mm_x, mm_y, mm_prod;
    logic                     mm_done;

    pfa_modmul #(
        .WORD_BITS (WORD_BITS)
    ) u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x     (mm_x),
        .y     (mm_y),
        .p     (p_reg),
        .done  (mm_done),
        .prod  (mm_prod)
    );

    assign p_small   = p_reg < WORD_BITS'(2);
    assign s_tready  = (state_reg == pfa_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[WORD_BITS-1:0] = out_data_reg;
    end

    // combinational ops on the reduced operands
    always_comb
    begin
        sum     = {1'b0, a_reg} + {1'b0, b_reg};
        sum_p   = {1'b0, a_reg} + {1'b0, b_reg} - {1'b0, p_reg};
        add_res = (sum >= {1'b0, p_reg}) ? sum_p[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
        diff    = a_reg - b_reg;
        // a below b wraps back into the field by adding p
        sub_res = (a_reg >= b_reg) ? diff : diff + p_reg;
        neg_res = (a_reg == '0) ? '0 : p_reg - a_reg;
    end

    // multiplicand follows the state the multiplier is working for
    always_comb
    begin
        case (state_reg)
            pfa_pkg::ST_RED_A,
            pfa_pkg::ST_RED_B:   mm_x = WORD_BITS'(1);
            pfa_pkg::ST_MUL:     mm_x = a_reg;
            pfa_pkg::ST_POW_SQ:  mm_x = t_reg;
            pfa_pkg::ST_POW_MUL: mm_x = a_reg;
            default:             mm_x = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        t_next         = t_reg;
        pcnt_next      = pcnt_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mm_start       = 1'b0;
        mm_y           = '0;

        case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next = s_tdata[pfa_pkg::OP_LSB +: pfa_pkg::OP_W];
                    e_next  = s_tdata[pfa_pkg::B_LSB +: WORD_BITS];
                    if (p_small)
                    begin
                        res_next   = '0;
                        state_next = pfa_pkg::ST_FINISH;
                    end
                    else
                    begin
                        // reduce operand_a as 1 * a mod p
                        mm_start   = 1'b1;
                        mm_y       = s_tdata[pfa_pkg::A_LSB +: WORD_BITS];
                        state_next = pfa_pkg::ST_RED_A;
                    end
                end
            end

            pfa_pkg::ST_RED_A:
            begin
                if (mm_done)
                begin
                    a_next     = mm_prod;
                    mm_start   = 1'b1;
                    mm_y       = e_reg;
                    state_next = pfa_pkg::ST_RED_B;
                end
            end

            pfa_pkg::ST_RED_B:
            begin
                if (mm_done)
                begin
                    b_next     = mm_prod;
                    state_next = pfa_pkg::ST_EXEC;
                end
            end

            pfa_pkg::ST_EXEC:
            begin
                state_next = pfa_pkg::ST_FINISH;
                case (op_reg)
                    pfa_pkg::OP_ADD: res_next = add_res;
                    pfa_pkg::OP_SUB: res_next = sub_res;
                    pfa_pkg::OP_NEG: res_next = neg_res;
                    pfa_pkg::OP_MUL:
                    begin
                        mm_start   = 1'b1;
                        mm_y       = b_reg;
                        state_next = pfa_pkg::ST_MUL;
                    end
                    pfa_pkg::OP_POW:
                    begin
                        // start from 1, leading zero bits just square 1
                        t_next     = WORD_BITS'(1);
                        pcnt_next  = CW'(WORD_BITS - 1);
                        mm_start   = 1'b1;
                        mm_y       = WORD_BITS'(1);
                        state_next = pfa_pkg::ST_POW_SQ;
                    end
                    default:         res_next = '0;
                endcase
            end

            pfa_pkg::ST_MUL:
            begin
                if (mm_done)
                begin
                    res_next   = mm_prod;
                    state_next = pfa_pkg::ST_FINISH;
                end
            end

            pfa_pkg::ST_POW_SQ,
            pfa_pkg::ST_POW_MUL:
            begin
                if (mm_done)
                begin
                    t_next = mm_prod;
                    if (state_reg == pfa_pkg::ST_POW_SQ && e_reg[WORD_BITS-1])
                    begin
                        mm_start   = 1'b1;
                        mm_y       = mm_prod;
                        state_next = pfa_pkg::ST_POW_MUL;
                    end
                    else if (pcnt_reg == '0)
                    begin
                        res_next   = mm_prod;
                        state_next = pfa_pkg::ST_FINISH;
                    end
                    else
                    begin
                        // next exponent bit
                        pcnt_next  = pcnt_reg - CW'(1);
                        e_next     = {e_reg[WORD_BITS-2:0], 1'b0};
                        mm_start   = 1'b1;
                        mm_y       = mm_prod;
                        state_next = pfa_pkg::ST_POW_SQ;
                    end
                end
            end

            pfa_pkg::ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = pfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            p_reg         <= pfa_pkg::MODULUS_RESET[WORD_BITS-1:0];
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                p_reg <= cfg_data[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        e_reg        <= e_next;
        t_reg        <= t_next;
        pcnt_reg     <= pcnt_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !p_small) |-> (out_data_reg < p_reg))
        else $error("result not below modulus");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == pfa_pkg::ST_FINISH))
        else $error("result raised outside finish");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != pfa_pkg::ST_IDLE))
        else $error("request accepted but sequencer stayed idle");
`endif

endmodule

@@ test/pfa_checker.sv @@
module pfa_checker #(
    parameter int WORD_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [pfa_pkg::REQ_W-1:0]   s_tdata,    // op, operand_a, operand_b
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [pfa_pkg::FIELD_W-1:0] m_tdata,    // result
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [pfa_pkg::FIELD_W-1:0] cfg_data,
    output int                          fail_count,
    output int                          outstanding,
    output int                          checked
);

    localparam logic [pfa_pkg::FIELD_W-1:0] WORD_MASK =
        {pfa_pkg::FIELD_W{1'b1}} >> (pfa_pkg::FIELD_W - WORD_BITS);
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [pfa_pkg::OP_W-1:0]    op;
        logic [pfa_pkg::FIELD_W-1:0] a;
        logic [pfa_pkg::FIELD_W-1:0] b;
        logic [pfa_pkg::FIELD_W-1:0] p;
        logic [pfa_pkg::FIELD_W-1:0] result;
    } field_op_t;

    field_op_t                   pending_q [$];
    logic [pfa_pkg::FIELD_W-1:0] modulus_copy = pfa_pkg::MODULUS_RESET;
    int                          n_fail = 0;
    int                          n_checked = 0;
    field_op_t                   req;
    field_op_t                   head;

    // x + y mod p with one conditional subtraction, carry included
    function automatic logic [pfa_pkg::FIELD_W-1:0] fe_add(
        input logic [pfa_pkg::FIELD_W-1:0] x, y, p);
        logic [pfa_pkg::FIELD_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s[pfa_pkg::FIELD_W] || s[pfa_pkg::FIELD_W-1:0] >= p)
            s = s - {1'b0, p};
        return s[pfa_pkg::FIELD_W-1:0];
    endfunction

    // double-and-add over the multiplier bits, msb first
    function automatic logic [pfa_pkg::FIELD_W-1:0] fe_mul(
        input logic [pfa_pkg::FIELD_W-1:0] x, y, p);
        logic [pfa_pkg::FIELD_W-1:0] acc;
        acc = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            acc = fe_add(acc, acc, p);
            if (y[i])
                acc = fe_add(acc, x, p);
        end
        return acc;
    endfunction

    function automatic logic [pfa_pkg::FIELD_W-1:0] fe_pow(
        input logic [pfa_pkg::FIELD_W-1:0] x, e, p);
        int                          top_bit;
        logic [pfa_pkg::FIELD_W-1:0] acc;
        top_bit = -1;
        for (int i = 0; i < WORD_BITS; i++)
            if (e[i])
                top_bit = i;
        if (top_bit < 0)
            return pfa_pkg::FIELD_W'(1);
        acc = x;
        for (int i = top_bit - 1; i >= 0; i--) begin
            acc = fe_mul(acc, acc, p);
            if (e[i])
                acc = fe_mul(acc, x, p);
        end
        return acc;
    endfunction

    function automatic logic [pfa_pkg::FIELD_W-1:0] field_result(
        input logic [pfa_pkg::OP_W-1:0]    op,
        input logic [pfa_pkg::FIELD_W-1:0] a_in, b_in,
        input logic [pfa_pkg::FIELD_W-1:0] p_in);
        logic [pfa_pkg::FIELD_W-1:0] p;
        logic [pfa_pkg::FIELD_W-1:0] e;
        logic [pfa_pkg::FIELD_W-1:0] a;
        logic [pfa_pkg::FIELD_W-1:0] b;
        p = p_in & WORD_MASK;
        e = b_in & WORD_MASK;
        if (p < 2)
            return '0;
        a = (a_in & WORD_MASK) % p;
        b = e % p;
        case (op)
            pfa_pkg::OP_ADD: return fe_add(a, b, p);
            pfa_pkg::OP_SUB: return (a >= b) ? a - b : p - (b - a);
            pfa_pkg::OP_MUL: return fe_mul(a, b, p);
            pfa_pkg::OP_NEG: return (a == '0) ? '0 : p - a;
            pfa_pkg::OP_POW: return fe_pow(a, e, p);
            default:         return '0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            modulus_copy = pfa_pkg::MODULUS_RESET;
            pending_q.delete();
            outstanding <= 0;
        end
        else begin
            // results first: one accepted at this edge belongs to an older request
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("%0t: result %h with no request pending", $realtime, m_tdata);
                end
                else begin
                    head = pending_q.pop_front();
                    n_checked++;
                    if (m_tdata !== head.result) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS)
                            $display("%0t: op %0d a %h b %h p %h expected %h got %h",
                                     $realtime, head.op, head.a, head.b, head.p,
                                     head.result, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                req.op     = s_tdata[pfa_pkg::OP_LSB +: pfa_pkg::OP_W];
                req.a      = s_tdata[pfa_pkg::A_LSB +: pfa_pkg::FIELD_W];
                req.b      = s_tdata[pfa_pkg::B_LSB +: pfa_pkg::FIELD_W];
                req.p      = modulus_copy;
                req.result = field_result(req.op, req.a, req.b, req.p);
                pending_q.push_back(req);
            end
            if (cfg_valid && cfg_ready)
                modulus_copy = cfg_data;
            outstanding <= pending_q.size();
        end
        fail_count <= n_fail;
        checked    <= n_checked;
    end

endmodule

@@ test/prime_field_alu_tb.sv @@
module prime_field_alu_tb;

    localparam int     WORD_BITS    = 64;
    localparam int     CLK_PERIOD   = 20;
    localparam int     RESET_CYCLES = 12;
    localparam int     MAX_IDLE     = 14;
    localparam int     DRAIN_CYCLES = 300;
    // covers the slowest run: about 110 requests, all of them power, plus idling, with margin
    localparam longint LIMIT_CYCLES = 5_000_000;
    localparam int     N_PHASES     = 8;

    localparam logic [pfa_pkg::FIELD_W-1:0] ALL_ONES      = '1;
    localparam logic [pfa_pkg::OP_W-1:0]    OP_RSVD_FIRST = pfa_pkg::OP_POW + 1'b1;
    localparam logic [pfa_pkg::OP_W-1:0]    OP_RSVD_LAST  = '1;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;

    // request stream
    logic                        s_tvalid;
    logic                        s_tready;
    logic [pfa_pkg::REQ_W-1:0]   s_tdata;    // op[2:0], operand_a[66:3], operand_b[130:67], pad
    // result stream
    logic                        m_tvalid;
    logic                        m_tready;
    logic [pfa_pkg::FIELD_W-1:0] m_tdata;    // result[63:0]
    // modulus write channel
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [pfa_pkg::FIELD_W-1:0] cfg_data;

    int                          fail_count;
    int                          outstanding;
    int                          checked;

    // set for a phase to run both sides back to back
    bit                          steady = 1'b0;
    int                          op_seen [2**pfa_pkg::OP_W];
    int                          n_requests = 0;
    int                          n_settings = 1;

    // moduli after the reset value: small prime, all ones (composite), the two
    // degenerate ones, an even one, mid and large primes, then back to the reset value
    logic [pfa_pkg::FIELD_W-1:0] phase_moduli [N_PHASES] = '{
        64'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd0,
        64'd1000, 64'd1_000_000_007, 64'h1FFF_FFFF_FFFF_FFFF, pfa_pkg::MODULUS_RESET
    };
    int unsigned                 phase_items [N_PHASES] = '{11, 11, 6, 6, 11, 11, 11, 12};

    always #(CLK_PERIOD / 2) clk = ~clk;

    prime_field_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts and compares
    pfa_checker #(
        .WORD_BITS (WORD_BITS)
    ) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    function automatic logic [pfa_pkg::FIELD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // field operand: reduced random values, with zero, p-1, p, all ones and unreduced values mixed in
    function automatic logic [pfa_pkg::FIELD_W-1:0] random_element(
        input logic [pfa_pkg::FIELD_W-1:0] p);
        logic [pfa_pkg::FIELD_W-1:0] r;
        r = rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return p - 1'b1;
            2:       return p;
            3:       return ALL_ONES;
            4, 5:    return r;
            default: return (p == '0) ? r : r % p;
        endcase
    endfunction

    // exponent for power: zero, one, short, all ones or a full random word
    function automatic logic [pfa_pkg::FIELD_W-1:0] random_exponent();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return pfa_pkg::FIELD_W'(1);
            2:       return pfa_pkg::FIELD_W'($urandom_range(2, 255));
            3:       return ALL_ONES;
            default: return rand_word();
        endcase
    endfunction

    // one request on the slave side, after a random gap unless the phase is steady;
    // tvalid stays high on return so back-to-back requests need no extra edge
    task automatic push_request(input logic [pfa_pkg::OP_W-1:0] op,
                                input logic [pfa_pkg::FIELD_W-1:0] a, b);
        logic [pfa_pkg::REQ_W-1:0] word;
        int unsigned               gap;
        word = '0;
        word[pfa_pkg::OP_LSB +: pfa_pkg::OP_W]   = op;
        word[pfa_pkg::A_LSB +: pfa_pkg::FIELD_W] = a;
        word[pfa_pkg::B_LSB +: pfa_pkg::FIELD_W] = b;
        gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        op_seen[op]++;
        n_requests++;
    endtask

    // drop tvalid and wait until every request has its result back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // modulus write, only called with the unit idle
    task automatic load_modulus(input logic [pfa_pkg::FIELD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(input int unsigned count, input logic [pfa_pkg::FIELD_W-1:0] p);
        logic [pfa_pkg::OP_W-1:0]    op;
        logic [pfa_pkg::FIELD_W-1:0] b;
        int unsigned                 pick;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 4)
                op = pfa_pkg::OP_ADD;
            else if (pick < 8)
                op = pfa_pkg::OP_SUB;
            else if (pick < 12)
                op = pfa_pkg::OP_MUL;
            else if (pick < 15)
                op = pfa_pkg::OP_NEG;
            else if (pick < 18)
                op = pfa_pkg::OP_POW;
            else
                op = pfa_pkg::OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            b = (op == pfa_pkg::OP_POW) ? random_exponent() : random_element(p);
            push_request(op, random_element(p), b);
        end
    endtask

    // result side: random stall before each result, none in steady phases
    initial begin
        int unsigned hold;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            hold = steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // stimulus and verdict
    initial begin
        logic [pfa_pkg::FIELD_W-1:0] p;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        foreach (op_seen[i])
            op_seen[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests under the reset modulus
        p = pfa_pkg::MODULUS_RESET;
        push_request(pfa_pkg::OP_ADD, p - 1'b1, p - 1'b1);     // sum carries out of the word
        push_request(pfa_pkg::OP_ADD, '0, '0);
        push_request(pfa_pkg::OP_ADD, ALL_ONES, ALL_ONES);     // both operands unreduced
        push_request(pfa_pkg::OP_ADD, pfa_pkg::FIELD_W'(1), p - 1'b1);  // sum equals p exactly
        push_request(pfa_pkg::OP_SUB, '0, p - 1'b1);           // a < b wraps through p
        push_request(pfa_pkg::OP_SUB, p - 1'b1, '0);
        push_request(pfa_pkg::OP_SUB, pfa_pkg::FIELD_W'(12345), pfa_pkg::FIELD_W'(12345));
        push_request(pfa_pkg::OP_SUB, ALL_ONES, p);
        push_request(pfa_pkg::OP_MUL, p - 1'b1, p - 1'b1);
        push_request(pfa_pkg::OP_MUL, ALL_ONES, ALL_ONES);
        push_request(pfa_pkg::OP_MUL, '0, rand_word() % p);
        push_request(pfa_pkg::OP_NEG, '0, ALL_ONES);           // zero stays zero, b ignored
        push_request(pfa_pkg::OP_NEG, p, rand_word());         // reduces to zero first
        push_request(pfa_pkg::OP_NEG, pfa_pkg::FIELD_W'(1), '0);
        push_request(pfa_pkg::OP_NEG, ALL_ONES, '0);
        push_request(pfa_pkg::OP_POW, rand_word() % p, '0);    // zero exponent gives one
        push_request(pfa_pkg::OP_POW, '0, '0);
        push_request(pfa_pkg::OP_POW, '0, pfa_pkg::FIELD_W'(5));
        push_request(pfa_pkg::OP_POW, pfa_pkg::FIELD_W'(2), pfa_pkg::FIELD_W'(1));
        push_request(pfa_pkg::OP_POW, rand_word() % p, ALL_ONES);   // every exponent bit set
        push_request(pfa_pkg::OP_POW, ALL_ONES, p - 1'b1);     // unreduced base, raw exponent
        for (int c = OP_RSVD_FIRST; c <= OP_RSVD_LAST; c++)
            push_request(pfa_pkg::OP_W'(c), rand_word(), rand_word());

        run_random(8, p);

        // one phase per modulus; writes only with nothing in flight
        for (int k = 0; k < N_PHASES; k++) begin
            drain_results();
            load_modulus(phase_moduli[k]);
            steady = (k == 5) || ($urandom_range(0, 3) == 0);
            run_random(phase_items[k], phase_moduli[k]);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: add %0d sub %0d mul %0d neg %0d pow %0d unused codes %0d",
                 n_requests, op_seen[pfa_pkg::OP_ADD], op_seen[pfa_pkg::OP_SUB],
                 op_seen[pfa_pkg::OP_MUL], op_seen[pfa_pkg::OP_NEG],
                 op_seen[pfa_pkg::OP_POW],
                 n_requests - op_seen[pfa_pkg::OP_ADD] - op_seen[pfa_pkg::OP_SUB]
                 - op_seen[pfa_pkg::OP_MUL] - op_seen[pfa_pkg::OP_NEG]
                 - op_seen[pfa_pkg::OP_POW]);
        $display("%0d results checked over %0d moduli (degenerate, even, all ones), %0d fails",
                 checked, n_settings, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hard stop in case a handshake never completes
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("run limit hit with %0d results still outstanding", outstanding);
        $display("TEST FAILED");
        $finish;
    end

endmodule
